[hdl/spi_register_transaction_master_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the SPI register transaction master
// Clocked, reset-qualified property wrappers shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef SPI_REGISTER_TRANSACTION_MASTER_ASSERT_SVH
`define SPI_REGISTER_TRANSACTION_MASTER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SRTM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SRTM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/srtm_pkg.sv]
// ---------------------------------------------------------------------------
// SPI register transaction master package
// Request and result types, request kinds and the sequencer phase encoding.
// ---------------------------------------------------------------------------
package srtm_pkg;

  localparam int unsigned WaitW = 12;

  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_STROBE = 3'd1;
  localparam logic [2:0] KIND_WRITE  = 3'd2;
  localparam logic [2:0] KIND_READ   = 3'd3;
  localparam logic [2:0] KIND_STATUS = 3'd4;

  localparam logic [7:0]       READ_FLAG     = 8'h80;
  localparam logic [7:0]       STATUS_FLAG   = 8'hC0;
  localparam logic [7:0]       DUMMY_BYTE    = 8'h00;
  localparam logic [WaitW-1:0] WAIT_LIMIT_RST = 12'd3000;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_WAIT = 5'b00010,
    PH_SET  = 5'b00100,
    PH_RISE = 5'b01000,
    PH_FALL = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] addr;
    logic [7:0] wdata;
    logic       miso;
  } req_t;

  typedef struct packed {
    logic       cs_n;
    logic       sck;
    logic       mosi;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rdata;
    logic       timed_out;
  } res_t;

endpackage

[hdl/srtm_chan_if.sv]
// ---------------------------------------------------------------------------
// SPI register transaction master channel
// Valid/ready channel carrying one packed payload per request.
// ---------------------------------------------------------------------------
interface srtm_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/srtm_core.sv]
// ---------------------------------------------------------------------------
// SPI register transaction master sequencer
// Holds the transaction state and works out one tick per enabled cycle.
// ---------------------------------------------------------------------------
module srtm_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  srtm_pkg::req_t                req,
  input  logic [srtm_pkg::WaitW-1:0]    wait_limit,
  output srtm_pkg::res_t                res
);
  import srtm_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [2:0]       bit_idx_r, bit_idx_nxt;
  logic             byte_idx_r, byte_idx_nxt;
  logic [7:0]       tx_shift_r, tx_shift_nxt;
  logic [7:0]       rx_shift_r, rx_shift_nxt;
  logic [7:0]       tx_second_r, tx_second_nxt;
  logic [7:0]       rx_first_r, rx_first_nxt;
  logic [2:0]       req_kind_r, req_kind_nxt;
  logic [WaitW-1:0] wait_cnt_r, wait_cnt_nxt;
  logic             expired_r, expired_nxt;
  logic             mosi_r, mosi_nxt;
  logic [WaitW-1:0] wait_inc;
  logic [7:0]       rx_in;
  logic             done;
  logic [7:0]       rdata;
  logic             tmo;

  assign wait_inc = wait_cnt_r + 1'b1;
  assign rx_in    = {rx_shift_r[6:0], req.miso};

  always_comb begin
    phase_nxt     = phase_r;
    bit_idx_nxt   = bit_idx_r;
    byte_idx_nxt  = byte_idx_r;
    tx_shift_nxt  = tx_shift_r;
    rx_shift_nxt  = rx_shift_r;
    tx_second_nxt = tx_second_r;
    rx_first_nxt  = rx_first_r;
    req_kind_nxt  = req_kind_r;
    wait_cnt_nxt  = wait_cnt_r;
    expired_nxt   = expired_r;
    mosi_nxt      = mosi_r;
    done          = 1'b0;
    rdata         = 8'd0;
    tmo           = 1'b0;

    unique case (phase_r)
      PH_IDLE: begin
        case (req.kind) inside
          KIND_STROBE, KIND_WRITE, KIND_READ, KIND_STATUS: begin
            req_kind_nxt  = req.kind;
            tx_shift_nxt  = req.addr;
            tx_second_nxt = DUMMY_BYTE;
            if (req.kind == KIND_WRITE) begin
              tx_second_nxt = req.wdata;
            end else if (req.kind == KIND_READ) begin
              tx_shift_nxt = req.addr | READ_FLAG;
            end else if (req.kind == KIND_STATUS) begin
              tx_shift_nxt = req.addr | STATUS_FLAG;
            end
            bit_idx_nxt  = 3'd7;
            byte_idx_nxt = 1'b0;
            rx_shift_nxt = 8'd0;
            rx_first_nxt = 8'd0;
            wait_cnt_nxt = '0;
            expired_nxt  = 1'b0;
            phase_nxt    = PH_WAIT;
          end
          default: ;
        endcase
      end
      PH_WAIT: begin
        if (!req.miso) begin
          phase_nxt = PH_SET;
        end else begin
          wait_cnt_nxt = wait_inc;
          // A wrapped count also ends the wait; a zero limit acts as one, as the compare then holds at once.
          if (wait_inc >= wait_limit || wait_inc == '0) begin
            expired_nxt = 1'b1;
            phase_nxt   = PH_SET;
          end
        end
      end
      PH_SET: begin
        mosi_nxt  = tx_shift_r[bit_idx_r];
        phase_nxt = PH_RISE;
      end
      PH_RISE: begin
        phase_nxt = PH_FALL;
      end
      PH_FALL: begin
        rx_shift_nxt = rx_in;
        if (bit_idx_r != 3'd0) begin
          bit_idx_nxt = bit_idx_r - 3'd1;
          phase_nxt   = PH_SET;
        end else if (!byte_idx_r && req_kind_r != KIND_STROBE) begin
          rx_first_nxt = rx_in;
          tx_shift_nxt = tx_second_r;
          rx_shift_nxt = 8'd0;
          byte_idx_nxt = 1'b1;
          bit_idx_nxt  = 3'd7;
          phase_nxt    = PH_SET;
        end else begin
          done         = 1'b1;
          rdata        = (req_kind_r == KIND_WRITE) ? rx_first_r : rx_in;
          tmo          = expired_r;
          bit_idx_nxt  = 3'd7;
          byte_idx_nxt = 1'b0;
          phase_nxt    = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_idx_r   <= 3'd7;
      byte_idx_r  <= 1'b0;
      tx_shift_r  <= 8'd0;
      rx_shift_r  <= 8'd0;
      tx_second_r <= 8'd0;
      rx_first_r  <= 8'd0;
      req_kind_r  <= KIND_TICK;
      wait_cnt_r  <= '0;
      expired_r   <= 1'b0;
      mosi_r      <= 1'b0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      bit_idx_r   <= bit_idx_nxt;
      byte_idx_r  <= byte_idx_nxt;
      tx_shift_r  <= tx_shift_nxt;
      rx_shift_r  <= rx_shift_nxt;
      tx_second_r <= tx_second_nxt;
      rx_first_r  <= rx_first_nxt;
      req_kind_r  <= req_kind_nxt;
      wait_cnt_r  <= wait_cnt_nxt;
      expired_r   <= expired_nxt;
      mosi_r      <= mosi_nxt;
    end
  end

  always_comb begin
    res.cs_n      = (phase_nxt == PH_IDLE);
    res.sck       = (phase_nxt == PH_FALL);
    res.mosi      = mosi_nxt;
    res.busy_res  = (phase_nxt != PH_IDLE);
    res.done_res  = done;
    res.rdata     = rdata;
    res.timed_out = tmo;
  end

endmodule

[hdl/spi_register_transaction_master.sv]
// ---------------------------------------------------------------------------
// SPI register transaction master
// Pin-level SPI mode-0 master for single register accesses to a radio.
// ---------------------------------------------------------------------------
// Every request on in_ch is one tick of the SPI sequence and yields exactly one
// result on out_ch holding the pin levels after that tick, plus busy, done,
// the returned byte and the timeout flag. One request is taken per clock
// cycle when the result side keeps up; each request is held in the input
// register, stepped by the sequencer, and its result held in the result
// register, which drives out_ch towards the consumer. A transaction request
// (strobe, register write, register read or status read) is only honoured
// while idle. Chip select then drops and the block waits for MISO to go low,
// for at most the number of ticks held in the wait limit register (written
// through cfg_we and cfg_wdata, 3000 after reset); if the wait runs out the
// transaction still goes ahead and timed_out is raised with done. Each bit
// takes three ticks: MOSI is set, SCK rises, then MISO is sampled as SCK falls,
// so a strobe lasts 24 ticks after the wait and two-byte accesses 48 ticks.
// The wait limit should only be written while no transaction is running.
`include "spi_register_transaction_master_assert.svh"

module spi_register_transaction_master (
  input  logic                       clk,
  input  logic                       rst_n,
  srtm_chan_if.sink                  in_ch,
  srtm_chan_if.source                out_ch,
  input  logic                       cfg_we,
  input  logic [srtm_pkg::WaitW-1:0] cfg_wdata
);
  import srtm_pkg::*;

  // Wait limit register; the user must write it only while the block is idle, as the block does not enforce it.
  logic [WaitW-1:0] wait_limit_r;

  // Input register stage: holds the request that the sequencer steps on next.
  logic in_valid_r;
  req_t in_req_r;

  // Result register stage: decouples the sequencer from the result consumer.
  logic out_valid_r;
  res_t out_res_r;

  logic out_free;
  logic step_en;
  logic in_take;
  res_t step_res;

  // The result register can load when empty or being emptied this cycle, and
  // the input register can load when empty or when its contents move on.
  assign out_free = !out_valid_r || out_ch.ready;
  assign step_en  = in_valid_r && out_free;
  assign in_take  = in_ch.valid && in_ch.ready;

  assign in_ch.ready  = !in_valid_r || out_free;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_limit_r <= WAIT_LIMIT_RST;
    end else if (cfg_we) begin
      wait_limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (step_en) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_req_r <= in_ch.data;
    end
  end

  // The sequencer advances exactly once per request, as it enters the result
  // register.
  srtm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .req        (in_req_r),
    .wait_limit (wait_limit_r),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= step_res;
    end
  end

  // Chip select and busy are two views of the same phase.
  `SRTM_ASSERT_NOW(a_cs_busy, out_valid_r, out_res_r.cs_n != out_res_r.busy_res, "cs_n and busy disagree")
  // A completing tick always leaves the block idle.
  `SRTM_ASSERT_NOW(a_done_idle, out_valid_r && out_res_r.done_res, !out_res_r.busy_res, "done while busy")
  // SCK is only high inside a transaction.
  `SRTM_ASSERT_NOW(a_sck_busy, out_valid_r && out_res_r.sck, out_res_r.busy_res, "sck high while idle")
  // Timeout and returned data are reported only with done.
  `SRTM_ASSERT_NOW(a_tmo_done, out_valid_r && !out_res_r.done_res, !out_res_r.timed_out && out_res_r.rdata == 8'd0, "result without done")
  // A held request is stepped as soon as the result register has room.
  `SRTM_ASSERT_NEXT(a_no_loss, in_valid_r && out_free, out_valid_r, "stepped request lost")

endmodule

[tb/sv/testbench.sv]
// ---------------------------------------------------------------------------
// SPI register transaction master testbench
// Drives tick requests with a simple slave model on MISO, predicts every result
// with a cycle model of the sequencer and checks each result field by field.
// ---------------------------------------------------------------------------
module testbench;
  import srtm_pkg::*;

  // Kinds above the status read carry no request and are treated as ticks.
  localparam logic [2:0] KIND_RSVD5 = 3'd5;
  localparam logic [2:0] KIND_RSVD6 = 3'd6;
  localparam logic [2:0] KIND_RSVD7 = 3'd7;

  localparam logic [WaitW-1:0] WAIT_MAX = '1;
  localparam int NO_CHANGE = -1;   // leave the wait limit as it is
  localparam int HOLD_HIGH = 5000; // slave keeps MISO high past any limit
  localparam int RAND_ITEMS = 100; // requests per random phase
  localparam int NUM_PHASES = 5;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [WaitW-1:0] cfg_wdata;

  srtm_chan_if #(.T(req_t)) in_ch ();
  srtm_chan_if #(.T(res_t)) out_ch ();

  spi_register_transaction_master i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk <= 1'b0;
    #5;
    clk <= 1'b1;
    #5;
  end

  // -------------------------------------------------------------------------
  // Cycle model of the sequencer. It is advanced once per accepted request and
  // gives the pin levels and flags that the block should report for that tick.
  // -------------------------------------------------------------------------
  phase_t           ph;
  logic [2:0]       bit_idx;
  logic             byte_idx;
  logic [7:0]       tx_sr;
  logic [7:0]       rx_sr;
  logic [7:0]       tx_next;
  logic [7:0]       rx_first;
  logic [2:0]       cur_kind;
  logic [WaitW-1:0] wait_cnt;
  logic             wait_exp;
  logic             mosi_q;
  logic [WaitW-1:0] wait_limit;

  function automatic void reset_model();
    ph         = PH_IDLE;
    bit_idx    = 3'd7;
    byte_idx   = 1'b0;
    tx_sr      = '0;
    rx_sr      = '0;
    tx_next    = '0;
    rx_first   = '0;
    cur_kind   = KIND_TICK;
    wait_cnt   = '0;
    wait_exp   = 1'b0;
    mosi_q     = 1'b0;
    wait_limit = WAIT_LIMIT_RST;
  endfunction

  function automatic res_t spi_tick(input req_t r);
    res_t o;
    o = '0;
    case (ph)
      PH_IDLE: begin
        // Only the four transaction kinds start anything; the rest are ticks.
        if (r.kind >= KIND_STROBE && r.kind <= KIND_STATUS) begin
          cur_kind = r.kind;
          case (r.kind)
            KIND_STROBE: begin
              tx_sr   = r.addr;
              tx_next = DUMMY_BYTE;
            end
            KIND_WRITE: begin
              tx_sr   = r.addr;
              tx_next = r.wdata;
            end
            KIND_READ: begin
              tx_sr   = r.addr | READ_FLAG;
              tx_next = DUMMY_BYTE;
            end
            default: begin
              tx_sr   = r.addr | STATUS_FLAG;
              tx_next = DUMMY_BYTE;
            end
          endcase
          bit_idx  = 3'd7;
          byte_idx = 1'b0;
          rx_sr    = '0;
          rx_first = '0;
          wait_cnt = '0;
          wait_exp = 1'b0;
          ph       = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (!r.miso) begin
          ph = PH_SET;
        end else begin
          // A zero limit behaves as one: the greater-or-equal test catches it.
          wait_cnt = wait_cnt + 1'b1;
          if (wait_cnt >= wait_limit || wait_cnt == '0) begin
            wait_exp = 1'b1;
            ph       = PH_SET;
          end
        end
      end
      PH_SET: begin
        mosi_q = tx_sr[bit_idx];
        ph     = PH_RISE;
      end
      PH_RISE: begin
        ph = PH_FALL;
      end
      default: begin
        rx_sr = {rx_sr[6:0], r.miso};
        if (bit_idx != 3'd0) begin
          bit_idx = bit_idx - 3'd1;
          ph      = PH_SET;
        end else if (!byte_idx && cur_kind != KIND_STROBE) begin
          rx_first = rx_sr;
          tx_sr    = tx_next;
          rx_sr    = '0;
          byte_idx = 1'b1;
          bit_idx  = 3'd7;
          ph       = PH_SET;
        end else begin
          // A write returns the status byte, the reads the second byte.
          o.done_res  = 1'b1;
          o.rdata     = (cur_kind == KIND_WRITE) ? rx_first : rx_sr;
          o.timed_out = wait_exp;
          bit_idx     = 3'd7;
          byte_idx    = 1'b0;
          ph          = PH_IDLE;
        end
      end
    endcase
    o.cs_n     = (ph == PH_IDLE);
    o.sck      = (ph == PH_FALL);
    o.mosi     = mosi_q;
    o.busy_res = (ph != PH_IDLE);
    return o;
  endfunction

  // -------------------------------------------------------------------------
  // Slave on the far side of the bus: it holds MISO high for a set number of
  // wait ticks, then presents its two reply bytes MSB first on the falling
  // SCK ticks. On every other tick MISO is noise.
  // -------------------------------------------------------------------------
  int         slv_wait_hi;
  int         slv_wait_seen;
  logic [7:0] slv_reply [2];

  function automatic req_t make_req(input logic [2:0] k, input logic [7:0] a,
                                    input logic [7:0] d);
    req_t r;
    r.kind  = k;
    r.addr  = a;
    r.wdata = d;
    if (ph == PH_WAIT) begin
      r.miso        = (slv_wait_seen < slv_wait_hi);
      slv_wait_seen = slv_wait_seen + 1;
    end else if (ph == PH_FALL) begin
      r.miso = slv_reply[byte_idx][bit_idx];
    end else begin
      r.miso = 1'($urandom_range(1));
    end
    return r;
  endfunction

  function automatic void new_slave(input int hi, input logic [7:0] b0,
                                    input logic [7:0] b1);
    slv_wait_hi   = hi;
    slv_wait_seen = 0;
    slv_reply[0]  = b0;
    slv_reply[1]  = b1;
  endfunction

  // -------------------------------------------------------------------------
  // Request side. The valid line is only lowered for an idle gap, so that a
  // run of back-to-back requests never sees two assignments in one step.
  // -------------------------------------------------------------------------
  res_t       tick_q [$];
  int         send_idle_pct;
  int         recv_stall_pct;
  int         rx_hold_left;
  int         errors;
  bit         typed_on;
  logic [7:0] typed_rdata;
  logic       typed_tmo;

  task automatic send_req(input req_t r);
    res_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= r;
    do @(posedge clk); while (!in_ch.ready);
    want = spi_tick(r);
    // Directed rows with a hand-written answer override the model's result.
    if (typed_on && want.done_res) begin
      want.rdata     = typed_rdata;
      want.timed_out = typed_tmo;
    end
    tick_q.push_back(want);
  endtask

  // Finish the running transaction with plain ticks, then let every result
  // come back and give the pipeline time to empty.
  task automatic settle();
    while (ph != PH_IDLE) send_req(make_req(KIND_TICK, '0, '0));
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tick_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(input logic [WaitW-1:0] v);
    settle();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we     <= 1'b0;
    wait_limit = v;
  endtask

  // -------------------------------------------------------------------------
  // Result side: checks each accepted result against the oldest prediction
  // and throttles ready, with a counted hold-off when one is asked for.
  // -------------------------------------------------------------------------
  function automatic void cmp_field(input string name, input logic [7:0] e,
                                    input logic [7:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
      errors++;
    end
  endfunction

  task automatic check_result(input res_t got);
    res_t e;
    if (tick_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %0h", $time, got);
      errors++;
    end else begin
      e = tick_q.pop_front();
      cmp_field("cs_n", e.cs_n, got.cs_n);
      cmp_field("sck", e.sck, got.sck);
      cmp_field("mosi", e.mosi, got.mosi);
      cmp_field("busy_res", e.busy_res, got.busy_res);
      cmp_field("done_res", e.done_res, got.done_res);
      cmp_field("rdata", e.rdata, got.rdata);
      cmp_field("timed_out", e.timed_out, got.timed_out);
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) check_result(out_ch.data);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Directed transactions. Each row optionally rewrites the wait limit first,
  // then runs one request to completion. Rows whose answer is plain from the
  // slave reply carry it; the others are checked against the model only.
  // -------------------------------------------------------------------------
  typedef struct {
    int         limit;
    logic [2:0] kind;
    logic [7:0] addr;
    logic [7:0] wdata;
    int         wait_hi;
    logic [7:0] reply0;
    logic [7:0] reply1;
    bit         noise;     // fill the busy ticks with ignored write requests
    bit         typed;
    logic [7:0] want_rdata;
    logic       want_tmo;
  } txn_row_t;

  txn_row_t txn_tab [18] = '{
    // Idle ticks straight after reset, including the unused kinds.
    '{NO_CHANGE, KIND_TICK,   8'h00, 8'h00, 0, 8'h00, 8'h00, 0, 0, 8'h00, 0},
    '{NO_CHANGE, KIND_RSVD5,  8'hFF, 8'hFF, 0, 8'h00, 8'h00, 0, 0, 8'h00, 0},
    '{NO_CHANGE, KIND_RSVD6,  8'h80, 8'h01, 0, 8'h00, 8'h00, 0, 0, 8'h00, 0},
    '{NO_CHANGE, KIND_RSVD7,  8'h7F, 8'hFE, 0, 8'h00, 8'h00, 0, 0, 8'h00, 0},
    // Strobes return the status byte; back to back with no idle tick.
    '{NO_CHANGE, KIND_STROBE, 8'h00, 8'h00, 0, 8'h00, 8'h00, 0, 1, 8'h00, 0},
    '{NO_CHANGE, KIND_STROBE, 8'hFF, 8'hFF, 3, 8'hFF, 8'h00, 0, 1, 8'hFF, 0},
    // Writes return the first byte received.
    '{NO_CHANGE, KIND_WRITE,  8'h3F, 8'hA5, 0, 8'h5A, 8'hFF, 0, 1, 8'h5A, 0},
    '{NO_CHANGE, KIND_WRITE,  8'h00, 8'hFF, 20, 8'h0F, 8'h00, 1, 1, 8'h0F, 0},
    // Reads return the second byte; in some rows busy ticks carry requests to be ignored.
    '{NO_CHANGE, KIND_READ,   8'h30, 8'h00, 0, 8'hF0, 8'hC3, 0, 1, 8'hC3, 0},
    '{NO_CHANGE, KIND_READ,   8'hFF, 8'hFF, 1, 8'hFF, 8'h00, 1, 1, 8'h00, 0},
    '{NO_CHANGE, KIND_STATUS, 8'h35, 8'h00, 0, 8'h00, 8'h81, 0, 1, 8'h81, 0},
    '{NO_CHANGE, KIND_STATUS, 8'h00, 8'h5A, 2, 8'hAA, 8'h55, 1, 0, 8'h00, 0},
    // A limit of one expires on the first high sample, and so does zero.
    '{1,         KIND_STROBE, 8'h36, 8'h00, HOLD_HIGH, 8'h0F, 8'h00, 0, 1, 8'h0F, 1},
    '{0,         KIND_READ,   8'h10, 8'h00, HOLD_HIGH, 8'h00, 8'h3C, 0, 1, 8'h3C, 1},
    // One high sample under a limit of two does not expire.
    '{2,         KIND_WRITE,  8'h20, 8'h01, 1, 8'h80, 8'h00, 0, 1, 8'h80, 0},
    // A long wait under the widest twelve-bit limit does not run out.
    '{int'(WAIT_MAX), KIND_STATUS, 8'h3D, 8'h00, 100, 8'h00, 8'hE7, 0, 1, 8'hE7, 0},
    // Back to the reset limit with a short wait.
    '{int'(WAIT_LIMIT_RST), KIND_WRITE, 8'h2E, 8'h00, 7, 8'h33, 8'h44, 0, 0, 8'h00, 0},
    '{NO_CHANGE, KIND_READ,   8'h01, 8'h00, 0, 8'h12, 8'h34, 0, 0, 8'h00, 0}
  };

  // -------------------------------------------------------------------------
  // Main sequence: reset, the directed rows, then random phases with their own
  // wait limit and idling. The last phase holds off the result side for a long
  // stretch so that the block fills up and stalls its request side; each phase
  // boundary pauses the sender until every result has come back.
  // -------------------------------------------------------------------------
  initial begin
    txn_row_t   row;
    logic [2:0] k;
    int         pick;
    int         send_pcts [NUM_PHASES];
    int         recv_pcts [NUM_PHASES];
    logic [WaitW-1:0] lim;

    send_pcts      = '{0, 55, 0, 15, 0};
    recv_pcts      = '{0, 0, 55, 15, 0};
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.data     = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rx_hold_left   = 0;
    errors         = 0;
    typed_on       = 1'b0;
    typed_rdata    = '0;
    typed_tmo      = 1'b0;
    reset_model();
    new_slave(0, '0, '0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (txn_tab[i]) begin
      row = txn_tab[i];
      if (row.limit != NO_CHANGE) set_limit(WaitW'(row.limit));
      new_slave(row.wait_hi, row.reply0, row.reply1);
      typed_on    = row.typed;
      typed_rdata = row.want_rdata;
      typed_tmo   = row.want_tmo;
      send_req(make_req(row.kind, row.addr, row.wdata));
      while (ph != PH_IDLE) begin
        if (row.noise) begin
          send_req(make_req(KIND_WRITE, 8'($urandom_range(255)), 8'($urandom_range(255))));
        end else begin
          send_req(make_req(KIND_TICK, '0, '0));
        end
      end
      typed_on = 1'b0;
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 1) begin
        lim = WAIT_MAX;
      end else if (p == 3) begin
        lim = '0;
      end else begin
        lim = WaitW'($urandom_range(1, 40));
      end
      set_limit(lim);
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      if (p == NUM_PHASES - 1) rx_hold_left = 60;
      for (int n = 0; n < RAND_ITEMS; n++) begin
        if (ph == PH_IDLE) begin
          // Mostly start a transaction; sometimes an idle or unused-kind tick.
          pick = $urandom_range(9);
          if (pick < 8) begin
            k = 3'($urandom_range(KIND_STROBE, KIND_STATUS));
          end else if (pick == 8) begin
            k = KIND_TICK;
          end else begin
            k = 3'($urandom_range(KIND_RSVD5, KIND_RSVD7));
          end
          if (k >= KIND_STROBE && k <= KIND_STATUS) begin
            new_slave(($urandom_range(3) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 3),
                      8'($urandom_range(255)), 8'($urandom_range(255)));
          end
        end else begin
          k = 3'($urandom_range(KIND_RSVD7));
        end
        send_req(make_req(k, 8'($urandom_range(255)), 8'($urandom_range(255))));
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tick_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("spi_register_transaction_master test passed");
    end else begin
      $display("spi_register_transaction_master test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, including the long waits.
  initial begin
    #4000000;
    $display("spi_register_transaction_master test failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/srtm_pkg.sv
hdl/srtm_chan_if.sv
hdl/srtm_core.sv
hdl/spi_register_transaction_master.sv
tb/sv/testbench.sv
